### hw/rtl/bdq_pkg.sv
package bdq_pkg;

	// Fixed field widths of the channels
	localparam int CMD_W    = 3;
	localparam int VAL_W    = 32;
	localparam int STATUS_W = 2;
	localparam int POS_W    = 6;
	localparam int COUNT_W  = 7;

	// Default sizing
	localparam int DEF_CAPACITY   = 64;
	localparam int DEF_DATA_WIDTH = 32;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH_FRONT = 3'd0,
		CMD_PUSH_BACK  = 3'd1,
		CMD_POP_FRONT  = 3'd2,
		CMD_POP_BACK   = 3'd3,
		CMD_REMOVE     = 3'd4,
		CMD_SEARCH     = 3'd5,
		CMD_PEEK       = 3'd6
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	// Broadcast control to every cell, already gated by item acceptance
	typedef struct packed {
		logic push_front;
		logic push_back;
		logic pop_front;
		logic remove_hit;
	} cell_ctl_t;

endpackage

### hw/rtl/bdq_cell.sv
module bdq_cell #(
	parameter int IDX        = 0,
	parameter int CAPACITY   = bdq_pkg::DEF_CAPACITY,
	parameter int DATA_WIDTH = bdq_pkg::DEF_DATA_WIDTH,
	localparam int CNT_W     = $clog2(CAPACITY + 1)
) (
	input  logic                  clk,
	input  logic [DATA_WIDTH-1:0] key,
	input  logic [DATA_WIDTH-1:0] left_d,
	input  logic [DATA_WIDTH-1:0] right_d,
	input  bdq_pkg::cell_ctl_t    ctl,
	input  logic [CNT_W-1:0]      count,
	input  logic                  shift_hit,
	output logic [DATA_WIDTH-1:0] data,
	output logic                  match,
	output logic [DATA_WIDTH-1:0] back_part
);
	import bdq_pkg::*;

	logic [DATA_WIDTH-1:0] data_q;
	logic [DATA_WIDTH-1:0] data_nxt;
	logic                  we;
	logic                  in_use;
	logic                  is_last;

	// Locate this cell within the held sequence
	assign in_use  = CNT_W'(IDX) < count;
	assign is_last = CNT_W'(IDX + 1) == count;

	// Compare against the key and offer the back entry
	assign match     = in_use && (data_q == key);
	assign back_part = is_last ? data_q : '0;
	assign data      = data_q;

	// Pick the next word: from the left, the key, or from the right
	always_comb begin
		we       = 1'b0;
		data_nxt = data_q;
		if (ctl.push_front) begin
			we       = 1'b1;
			data_nxt = left_d;
		end else if (ctl.push_back && (CNT_W'(IDX) == count)) begin
			we       = 1'b1;
			data_nxt = key;
		end else if (ctl.pop_front || (ctl.remove_hit && shift_hit)) begin
			we       = 1'b1;
			data_nxt = right_d;
		end
	end

	// Hold the entry
	always_ff @(posedge clk) begin
		if (we) begin
			data_q <= data_nxt;
		end
	end

endmodule

### hw/rtl/bdq_find.sv
module bdq_find #(
	parameter int CAPACITY = bdq_pkg::DEF_CAPACITY,
	localparam int IDX_W   = $clog2(CAPACITY)
) (
	input  logic [CAPACITY-1:0] hit,
	output logic [CAPACITY-1:0] prefix,
	output logic                found,
	output logic [IDX_W-1:0]    pos
);
	import bdq_pkg::*;

	localparam int LVLS = $clog2(CAPACITY);

	logic [CAPACITY-1:0] lvl [LVLS+1];
	logic [CAPACITY-1:0] first;

	// Spread each hit toward the back in log steps
	always_comb begin
		lvl[0] = hit;
		for (int l = 0; l < LVLS; l++) begin
			lvl[l+1] = lvl[l] | (lvl[l] << (1 << l));
		end
	end

	assign prefix = lvl[LVLS];
	assign found  = prefix[CAPACITY-1];
	assign first  = prefix & ~(prefix << 1);

	// Encode the one-hot first match
	always_comb begin
		pos = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (first[i]) begin
				pos = pos | IDX_W'(i);
			end
		end
	end

endmodule

### hw/rtl/bounded_deque_with_search_delete.sv
// Channel | Handshake             | Payload
// in      | in_valid / in_stall   | cmd, value
// out     | out_valid / out_stall | status, position, count, front_value, back_value
//
// One item per cycle sustained while in_stall stays low; the cells and stage 1
// update at the accepting edge, and the result register takes the item from stage 1
// when it can advance.
// Each in-use cell compares its entry; cells shift or load in the accepting cycle.
// Reset clears the occupancy and both handshake stages; no clearing pass.
// When the result register is stalled and a result is already pending, in_stall rises.
module bounded_deque_with_search_delete #(
	parameter int CAPACITY   = bdq_pkg::DEF_CAPACITY,
	parameter int DATA_WIDTH = bdq_pkg::DEF_DATA_WIDTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [bdq_pkg::CMD_W-1:0]     cmd,
	input  logic signed [bdq_pkg::VAL_W-1:0] value,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [bdq_pkg::STATUS_W-1:0]  status,
	output logic [bdq_pkg::POS_W-1:0]     position,
	output logic [bdq_pkg::COUNT_W-1:0]   count,
	output logic signed [bdq_pkg::VAL_W-1:0] front_value,
	output logic signed [bdq_pkg::VAL_W-1:0] back_value
);
	import bdq_pkg::*;

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int EXT_W = (DATA_WIDTH > VAL_W) ? DATA_WIDTH : VAL_W;

	logic [DATA_WIDTH-1:0] key;
	logic [DATA_WIDTH-1:0] cell_d    [CAPACITY];
	logic [DATA_WIDTH-1:0] back_part [CAPACITY];
	logic [CAPACITY-1:0]   hit;
	logic [CAPACITY-1:0]   prefix;
	logic                  found;
	logic [IDX_W-1:0]      find_pos;

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_nxt;
	logic             full;
	logic             empty;
	logic             accept;
	logic             s1_adv;

	cell_ctl_t ctl;
	cell_ctl_t cell_ctl;
	status_t   st;
	logic      report_pos;
	logic      inc;
	logic      dec;

	logic       valid_s1;
	status_t    status_s1;
	logic [IDX_W-1:0] pos_s1;

	logic                  out_valid_q;
	status_t               status_q;
	logic [POS_W-1:0]      position_q;
	logic [COUNT_W-1:0]    count_o_q;
	logic [VAL_W-1:0]      front_q;
	logic [VAL_W-1:0]      back_q;
	logic [DATA_WIDTH-1:0] back_sel;
	logic [EXT_W-1:0]      front_ext;
	logic [EXT_W-1:0]      back_ext;

	assign key = DATA_WIDTH'($unsigned(value));

	// Handshake: accept unless a pending result cannot move on
	assign s1_adv   = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !s1_adv;
	assign accept   = in_valid && !in_stall;

	assign full  = count_q == CNT_W'(CAPACITY);
	assign empty = count_q == '0;

	// Row of cells
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] left_d;
		logic [DATA_WIDTH-1:0] right_d;
		if (i == 0) begin : g_first
			assign left_d = key;
		end else begin : g_mid_l
			assign left_d = cell_d[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_d = cell_d[i];
		end else begin : g_mid_r
			assign right_d = cell_d[i+1];
		end
		bdq_cell #(
			.IDX       (i),
			.CAPACITY  (CAPACITY),
			.DATA_WIDTH(DATA_WIDTH)
		) u_cell (
			.clk      (clk),
			.key      (key),
			.left_d   (left_d),
			.right_d  (right_d),
			.ctl      (cell_ctl),
			.count    (count_q),
			.shift_hit(prefix[i]),
			.data     (cell_d[i]),
			.match    (hit[i]),
			.back_part(back_part[i])
		);
	end

	// First match and the shift mask behind it
	bdq_find #(
		.CAPACITY(CAPACITY)
	) u_find (
		.hit   (hit),
		.prefix(prefix),
		.found (found),
		.pos   (find_pos)
	);

	// Decode the command
	always_comb begin
		ctl        = '0;
		st         = ST_OK;
		report_pos = 1'b0;
		inc        = 1'b0;
		dec        = 1'b0;
		case (cmd_t'(cmd))
			CMD_PUSH_FRONT: begin
				if (full) begin
					st = ST_FULL;
				end else begin
					ctl.push_front = 1'b1;
					inc            = 1'b1;
				end
			end
			CMD_PUSH_BACK: begin
				if (full) begin
					st = ST_FULL;
				end else begin
					ctl.push_back = 1'b1;
					inc           = 1'b1;
				end
			end
			CMD_POP_FRONT: begin
				if (empty) begin
					st = ST_EMPTY;
				end else begin
					ctl.pop_front = 1'b1;
					dec           = 1'b1;
				end
			end
			CMD_POP_BACK: begin
				if (empty) begin
					st = ST_EMPTY;
				end else begin
					dec = 1'b1;
				end
			end
			CMD_REMOVE: begin
				if (found) begin
					ctl.remove_hit = 1'b1;
					dec            = 1'b1;
					report_pos     = 1'b1;
				end else begin
					st = ST_NOT_FOUND;
				end
			end
			CMD_SEARCH: begin
				if (found) begin
					report_pos = 1'b1;
				end else begin
					st = ST_NOT_FOUND;
				end
			end
			default: begin
				if (empty) begin
					st = ST_EMPTY;
				end
			end
		endcase
	end

	assign cell_ctl  = accept ? ctl : '0;
	assign count_nxt = inc ? count_q + CNT_W'(1) : (dec ? count_q - CNT_W'(1) : count_q);

	// Select the back entry from the cells
	always_comb begin
		back_sel = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			back_sel = back_sel | back_part[i];
		end
	end

	assign front_ext = empty ? '0 : EXT_W'(signed'(cell_d[0]));
	assign back_ext  = EXT_W'(signed'(back_sel));

	// Control state: occupancy and stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q  <= count_nxt;
				valid_s1 <= 1'b1;
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end
			if (valid_s1 && s1_adv) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Capture status and position, then the result with the updated ends
	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= st;
			pos_s1    <= report_pos ? find_pos : '0;
		end
		if (valid_s1 && s1_adv) begin
			status_q   <= status_s1;
			position_q <= POS_W'(pos_s1);
			count_o_q  <= COUNT_W'(count_q);
			front_q    <= front_ext[VAL_W-1:0];
			back_q     <= back_ext[VAL_W-1:0];
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign position    = position_q;
	assign count       = count_o_q;
	assign front_value = front_q;
	assign back_value  = back_q;

endmodule

### hw/rtl/bdq_checker.sv
module bdq_props (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic [bdq_pkg::STATUS_W-1:0]      status,
	input logic [bdq_pkg::POS_W-1:0]         position,
	input logic [bdq_pkg::COUNT_W-1:0]       count,
	input logic signed [bdq_pkg::VAL_W-1:0]  front_value,
	input logic signed [bdq_pkg::VAL_W-1:0]  back_value
);
	import bdq_pkg::*;

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(status) && $stable(count) && $stable(front_value))
		else $error("stalled result changed");

	// Empty status reports an empty sequence with cleared ends
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_EMPTY)
		|-> (count == '0) && (front_value == '0) && (back_value == '0))
		else $error("empty status with entries or stale ends");

	// A miss reports no position
	a_miss_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_NOT_FOUND) |-> position == '0)
		else $error("position set on a miss");

endmodule

bind bounded_deque_with_search_delete bdq_props u_bdq_props (.*);

### tb/sv/bdq_checker.sv
`timescale 1ns / 100ps

module bdq_checker
	import bdq_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic                       in_stall,
	input  logic [CMD_W-1:0]           cmd,
	input  logic signed [VAL_W-1:0]    value,
	input  logic                       out_valid,
	input  logic                       out_stall,
	input  logic [STATUS_W-1:0]        status,
	input  logic [POS_W-1:0]           position,
	input  logic [COUNT_W-1:0]         count,
	input  logic signed [VAL_W-1:0]    front_value,
	input  logic signed [VAL_W-1:0]    back_value,
	output int                         fail_count,
	output int                         waiting
);

	localparam int DEPTH = DEF_CAPACITY;

	typedef struct {
		status_t                    st;
		logic [POS_W-1:0]           pos;
		logic [COUNT_W-1:0]         cnt;
		logic signed [VAL_W-1:0]    front;
		logic signed [VAL_W-1:0]    back;
	} deque_result_t;

	// Shadow copy of the sequence, front at index 0
	logic signed [VAL_W-1:0] held[$];
	deque_result_t           results_due[$];

	// Apply one command to the shadow sequence and return the result it yields
	function automatic deque_result_t apply_command(logic [CMD_W-1:0] op,
		logic signed [VAL_W-1:0] v);
		deque_result_t r;
		int            at;
		r.st = ST_OK;
		r.pos = '0;
		at = -1;
		case (op)
			CMD_PUSH_FRONT: begin
				if (held.size() >= DEPTH) r.st = ST_FULL;
				else held.push_front(v);
			end
			CMD_PUSH_BACK: begin
				if (held.size() >= DEPTH) r.st = ST_FULL;
				else held.push_back(v);
			end
			CMD_POP_FRONT: begin
				if (held.size() == 0) r.st = ST_EMPTY;
				else void'(held.pop_front());
			end
			CMD_POP_BACK: begin
				if (held.size() == 0) r.st = ST_EMPTY;
				else void'(held.pop_back());
			end
			CMD_REMOVE, CMD_SEARCH: begin
				// first match from the front wins
				for (int i = 0; i < held.size(); i++) begin
					if (at < 0 && held[i] == v) at = i;
				end
				if (at < 0) begin
					r.st = ST_NOT_FOUND;
				end else begin
					r.pos = at[POS_W-1:0];
					if (op == CMD_REMOVE) held.delete(at);
				end
			end
			// peek, and the unused code acts as peek
			default: begin
				if (held.size() == 0) r.st = ST_EMPTY;
			end
		endcase
		r.cnt = COUNT_W'(held.size());
		if (held.size() == 0) begin
			r.front = '0;
			r.back = '0;
		end else begin
			r.front = held[0];
			r.back = held[held.size()-1];
		end
		return r;
	endfunction

	// Compare finished items against the oldest prediction, then record new ones
	always @(posedge clk or negedge arst_n) begin
		deque_result_t exp_r;
		if (!arst_n) begin
			held.delete();
			results_due.delete();
			waiting = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (results_due.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected result item: st=%0d pos=%0d cnt=%0d front=%0d back=%0d",
							status, position, count, front_value, back_value);
					fail_count++;
				end else begin
					exp_r = results_due.pop_front();
					if (status !== exp_r.st || position !== exp_r.pos || count !== exp_r.cnt ||
						front_value !== exp_r.front || back_value !== exp_r.back) begin
						if (fail_count < 10) begin
							$display("result mismatch at %0t", $realtime);
							$display("  expected st=%0d pos=%0d cnt=%0d front=%0d back=%0d",
								exp_r.st, exp_r.pos, exp_r.cnt, exp_r.front, exp_r.back);
							$display("  actual   st=%0d pos=%0d cnt=%0d front=%0d back=%0d",
								status, position, count, front_value, back_value);
						end
						fail_count++;
					end
				end
			end
			if (in_valid && !in_stall)
				results_due.push_back(apply_command(cmd, value));
			waiting = results_due.size();
		end
	end

endmodule

### tb/sv/bounded_deque_with_search_delete_test.sv
`timescale 1ns / 100ps

module bounded_deque_with_search_delete_test;

	import bdq_pkg::*;

	localparam int N_RANDOM = 1650;
	localparam int LIMIT = 200000;
	localparam int LONG_HOLD = 300;
	localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;
	localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFFFFFF;
	localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh80000000;
	localparam logic signed [VAL_W-1:0] VAL_NEG1 = -32'sd1;

	typedef enum {TREND_GROW, TREND_SHRINK, TREND_MIXED} trend_t;

	logic                       clk;
	logic                       arst_n = 1'b0;
	logic                       in_valid = 1'b0;
	logic                       in_stall;
	logic [CMD_W-1:0]           cmd = CMD_PEEK;
	logic signed [VAL_W-1:0]    value = '0;
	logic                       out_valid;
	logic                       out_stall = 1'b0;
	logic [STATUS_W-1:0]        status;
	logic [POS_W-1:0]           position;
	logic [COUNT_W-1:0]         count;
	logic signed [VAL_W-1:0]    front_value;
	logic signed [VAL_W-1:0]    back_value;
	int                         fail_count;
	int                         waiting;
	int                         cycles = 0;

	// Recently inserted values, reused as search and remove keys
	logic signed [VAL_W-1:0]    recent[16] = '{default: '0};
	int                         recent_wr = 0;

	bounded_deque_with_search_delete dut (
		.clk, .arst_n, .in_valid, .in_stall, .cmd, .value,
		.out_valid, .out_stall, .status, .position, .count, .front_value, .back_value
	);

	bdq_checker chk (
		.clk, .arst_n, .in_valid, .in_stall, .cmd, .value,
		.out_valid, .out_stall, .status, .position, .count, .front_value, .back_value,
		.fail_count, .waiting
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// Offer one item and hold it until accepted
	task automatic offer_item(input logic [CMD_W-1:0] op, input logic signed [VAL_W-1:0] v);
		in_valid <= 1'b1;
		cmd <= op;
		value <= v;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	function automatic logic signed [VAL_W-1:0] pick_value();
		int roll;
		roll = $urandom_range(0, 9);
		if (roll < 4) return $urandom;
		if (roll < 7) return $signed($urandom_range(0, 8)) - 4;
		if (roll < 8) begin
			case ($urandom_range(0, 3))
				0: return VAL_MAX;
				1: return VAL_MIN;
				2: return VAL_NEG1;
				default: return '0;
			endcase
		end
		return recent[$urandom_range(0, 15)];
	endfunction

	// Weight the command mix so the fill level drifts up, down or stays put
	function automatic logic [CMD_W-1:0] pick_command(trend_t t);
		int roll, pf, pb, popf, popb, rem, srch;
		roll = $urandom_range(0, 99);
		case (t)
			TREND_GROW: begin
				pf = 35; pb = 65; popf = 72; popb = 78; rem = 86; srch = 95;
			end
			TREND_SHRINK: begin
				pf = 12; pb = 24; popf = 50; popb = 72; rem = 86; srch = 95;
			end
			default: begin
				pf = 18; pb = 36; popf = 48; popb = 60; rem = 78; srch = 92;
			end
		endcase
		if (roll < pf) return CMD_PUSH_FRONT;
		if (roll < pb) return CMD_PUSH_BACK;
		if (roll < popf) return CMD_POP_FRONT;
		if (roll < popb) return CMD_POP_BACK;
		if (roll < rem) return CMD_REMOVE;
		if (roll < srch) return CMD_SEARCH;
		if (roll < 99) return CMD_PEEK;
		return CMD_UNUSED;
	endfunction

	// Receiver: random stall stretches, one long hold-off to fill the block
	initial begin
		int  rx_cycles;
		int  seg_len;
		int  seg_mode;
		bit  long_done;
		rx_cycles = 0;
		long_done = 1'b0;
		forever begin
			if (!long_done && rx_cycles >= 400) begin
				long_done = 1'b1;
				repeat (LONG_HOLD) begin
					@(posedge clk);
					out_stall <= 1'b1;
				end
				rx_cycles += LONG_HOLD;
			end else begin
				seg_mode = $urandom_range(0, 3);
				seg_len = $urandom_range(1, 40);
				repeat (seg_len) begin
					@(posedge clk);
					case (seg_mode)
						0: out_stall <= 1'b0;
						1: out_stall <= ($urandom_range(0, 3) == 0);
						2: out_stall <= $urandom_range(0, 1);
						default: out_stall <= ($urandom_range(0, 3) != 0);
					endcase
				end
				rx_cycles += seg_len;
			end
		end
	end

	// Sender: directed items, then bursts of random items
	initial begin
		trend_t                   trend;
		int                       phase_left;
		int                       burst;
		int                       gap;
		logic [CMD_W-1:0]         op;
		logic signed [VAL_W-1:0]  v;
		phase_left = 0;
		burst = 0;
		trend = TREND_GROW;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty sequence: every command that reads or removes
		offer_item(CMD_PEEK, $urandom);
		offer_item(CMD_POP_FRONT, $urandom);
		offer_item(CMD_POP_BACK, $urandom);
		offer_item(CMD_REMOVE, '0);
		offer_item(CMD_SEARCH, '0);
		// build [-1, MAX, MIN, 0, -1]
		offer_item(CMD_PUSH_FRONT, VAL_MAX);
		offer_item(CMD_PUSH_BACK, VAL_MIN);
		offer_item(CMD_PUSH_FRONT, VAL_NEG1);
		offer_item(CMD_PUSH_BACK, '0);
		offer_item(CMD_PUSH_BACK, VAL_NEG1);
		// first match wins; miss on a filled sequence
		offer_item(CMD_SEARCH, VAL_NEG1);
		offer_item(CMD_SEARCH, '0);
		offer_item(CMD_SEARCH, VAL_MIN);
		offer_item(CMD_SEARCH, 32'sd5);
		offer_item(CMD_REMOVE, 32'sd5);
		// remove in the middle, at the front, then at the back
		offer_item(CMD_REMOVE, '0);
		offer_item(CMD_REMOVE, VAL_NEG1);
		offer_item(CMD_REMOVE, VAL_NEG1);
		offer_item(CMD_PEEK, $urandom);
		offer_item(CMD_UNUSED, $urandom);
		// drain to empty from both ends
		offer_item(CMD_POP_FRONT, $urandom);
		offer_item(CMD_POP_BACK, $urandom);
		offer_item(CMD_PEEK, $urandom);
		offer_item(CMD_UNUSED, $urandom);

		for (int n = 0; n < N_RANDOM; n++) begin
			if (phase_left == 0) begin
				trend = trend_t'($urandom_range(0, 2));
				phase_left = $urandom_range(40, 150);
			end
			phase_left--;
			if (burst == 0) begin
				burst = $urandom_range(1, 30);
				gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				if (gap != 0) begin
					in_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			burst--;
			op = pick_command(trend);
			if (op == CMD_PUSH_FRONT || op == CMD_PUSH_BACK) begin
				v = pick_value();
				recent[recent_wr] = v;
				recent_wr = (recent_wr + 1) % 16;
			end else if (op == CMD_REMOVE || op == CMD_SEARCH) begin
				v = ($urandom_range(0, 9) < 7) ? recent[$urandom_range(0, 15)] : pick_value();
			end else begin
				v = $urandom;
			end
			offer_item(op, v);
		end

		// drain outstanding results, then allow for the pipeline
		in_valid <= 1'b0;
		@(posedge clk);
		while (waiting != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

### filelist.f
hw/rtl/bdq_pkg.sv
hw/rtl/bdq_cell.sv
hw/rtl/bdq_find.sv
hw/rtl/bounded_deque_with_search_delete.sv
hw/rtl/bdq_checker.sv
tb/sv/bdq_checker.sv
tb/sv/bounded_deque_with_search_delete_test.sv
